// ----- hdl/page_frame_bitmap_allocator_unit_defines.svh -----
// assertion macros used by the page frame allocator sequencer
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define PFBA_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("pfba assertion failed");
// consequent must hold in the cycle after the antecedent
`define PFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pfba assertion failed");
`else
`define PFBA_ASSERT(lbl, clk, rstn, expr)
`define PFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/pfba_pkg.sv -----
// shared widths, codes and structs of the page frame allocator
`default_nettype none
package pfba_pkg;

    // field widths
    localparam int PG_W   = 17;   // page counts and page numbers incl. limit
    localparam int IDX_W  = 16;   // page index field
    localparam int STAT_W = 2;

    // bitmap word geometry
    localparam int WORD_W = 32;
    localparam int OFF_W  = 5;
    localparam int WIDX_W = PG_W - OFF_W;

    localparam int CNT_W  = OFF_W + 1;   // set bits in one word

    localparam int DEF_MAX_PAGES = 65536;

    localparam logic [PG_W-1:0] TOTAL_RESET = PG_W'(65536);
    localparam logic [PG_W-1:0] COUNT_MAX   = '1;

    typedef enum logic [1:0] {
        FN_LOCK    = 2'd0,
        FN_FREE    = 2'd1,
        FN_RESERVE = 2'd2,
        FN_REQUEST = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_SKIP = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    // control of the shared word unit
    typedef struct packed {
        t_func            func;
        logic             first;
        logic             last;
        logic [OFF_W-1:0] lo_off;
        logic [OFF_W-1:0] hi_off;
    } t_wu_ctl;

    // word unit results
    typedef struct packed {
        logic [WORD_W-1:0] new_word;
        logic [CNT_W-1:0]  chg_cnt;
        logic              skip;
        logic              found;
        logic [OFF_W-1:0]  found_off;
    } t_wu_out;

    // one result item
    typedef struct packed {
        t_status         status;
        logic [IDX_W-1:0] page_index;
        logic [PG_W-1:0] pages_changed;
        logic [PG_W-1:0] free_pages;
        logic [PG_W-1:0] used_pages;
        logic [PG_W-1:0] reserved_pages;
    } t_result;

endpackage
`default_nettype wire

// ----- hdl/page_frame_bitmap_allocator_unit.sv -----
// top level of the bitmap page frame allocator
//
// Keeps one busy bit per page in a MAX_PAGES/32 x 32 bitmap memory plus used and
// reserved page counts. After reset a clearing pass writes one bitmap word per
// cycle, covering the whole bitmap, before the first request is taken;
// total_pages writes are accepted throughout. A lock, free or reserve request
// reads, then modifies and writes back, each 32-page bitmap word its in-range
// pages touch, after an accept step and before a handoff step; a page request
// does the same for each word scanned up to the word that holds the lowest free
// page (or to the tracked limit). Each word goes through the single-port
// read-modify-write of the bitmap memory and the shared word unit. Results wait
// in an output register, so the next request is taken while a finished result is still pending.
`default_nettype none
module page_frame_bitmap_allocator_unit
    import pfba_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [PG_W-1:0]  i_cfg_data,
    // requests
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_func,
    input  logic [IDX_W-1:0] i_page_start,
    input  logic [PG_W-1:0]  i_run_length,
    // results
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0] o_page_index,
    output logic [PG_W-1:0]  o_pages_changed,
    output logic [PG_W-1:0]  o_free_pages,
    output logic [PG_W-1:0]  o_used_pages,
    output logic [PG_W-1:0]  o_reserved_pages
);

    logic [PG_W-1:0] r_total_pages;
    logic            r_out_valid;
    t_result         r_out;
    logic            seq_res_valid, res_take;
    t_result         seq_res;

    // total_pages register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_pages <= TOTAL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_total_pages <= i_cfg_data;
        end
    end

    pfba_seq #(
        .MAX_PAGES (MAX_PAGES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_in_valid),
        .o_req_ready   (o_in_ready),
        .i_func        (t_func'(i_func)),
        .i_page_start  (i_page_start),
        .i_run_length  (i_run_length),
        .i_total_pages (r_total_pages),
        .o_res_valid   (seq_res_valid),
        .i_res_take    (res_take),
        .o_res         (seq_res)
    );

    // output register
    assign res_take = seq_res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= seq_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_page_index     = r_out.page_index;
    assign o_pages_changed  = r_out.pages_changed;
    assign o_free_pages     = r_out.free_pages;
    assign o_used_pages     = r_out.used_pages;
    assign o_reserved_pages = r_out.reserved_pages;

endmodule
`default_nettype wire

// ----- hdl/pfba_word_unit.sv -----
// shared bitmap word unit: range mask, set/clear, change count, first free bit
`default_nettype none
module pfba_word_unit
    import pfba_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  t_wu_ctl           i_ctl,
    output t_wu_out           o_res
);

    logic [WORD_W-1:0] mask_lo, mask_hi, mask;
    logic [WORD_W-1:0] cand, lowest, chg;
    logic [OFF_W-1:0]  hi_sh;
    logic [OFF_W-1:0]  found_off;

    // byte-wise popcount, then a small adder tree
    function automatic logic [CNT_W-1:0] popcount(input logic [WORD_W-1:0] w);
        logic [3:0] part [4];
        for (int k = 0; k < 4; k++) begin
            part[k] = '0;
            for (int b = 0; b < 8; b++) begin
                part[k] = part[k] + 4'(w[k*8+b]);
            end
        end
        return CNT_W'(part[0]) + CNT_W'(part[1]) + CNT_W'(part[2]) + CNT_W'(part[3]);
    endfunction

    // pages of the run that fall in this word
    assign hi_sh   = OFF_W'(WORD_W - 1) - i_ctl.hi_off;
    assign mask_lo = i_ctl.first ? ({WORD_W{1'b1}} << i_ctl.lo_off) : {WORD_W{1'b1}};
    assign mask_hi = i_ctl.last  ? ({WORD_W{1'b1}} >> hi_sh)        : {WORD_W{1'b1}};
    assign mask    = mask_lo & mask_hi;

    // free candidates and lowest one
    assign cand   = mask & ~i_word;
    assign lowest = cand & (~cand + WORD_W'(1));

    always_comb begin
        unique case (i_ctl.func)
            FN_REQUEST: chg = lowest;
            FN_FREE:    chg = mask & i_word;
            default:    chg = cand;
        endcase
    end

    // offset of the one-hot lowest free bit
    always_comb begin
        found_off = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (lowest[b]) begin
                found_off = found_off | OFF_W'(b);
            end
        end
    end

    assign o_res.found_off = found_off;
    assign o_res.new_word  = (i_ctl.func == FN_FREE) ? (i_word & ~chg) : (i_word | chg);
    assign o_res.chg_cnt   = popcount(chg);
    assign o_res.found     = |cand;
    assign o_res.skip      = (i_ctl.func == FN_FREE) ? (|cand) : (|(mask & i_word));

endmodule
`default_nettype wire

// ----- hdl/pfba_seq.sv -----
// sequencer with bitmap memory, page counters and clearing pass
`default_nettype none
`include "page_frame_bitmap_allocator_unit_defines.svh"
module pfba_seq
    import pfba_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_func            i_func,
    input  logic [IDX_W-1:0] i_page_start,
    input  logic [PG_W-1:0]  i_run_length,
    input  logic [PG_W-1:0]  i_total_pages,
    output logic             o_res_valid,
    input  logic             i_res_take,
    output t_result          o_res
);

    localparam int DEPTH  = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_MOD,
        S_DONE
    } t_state;

    t_state              r_state;
    t_func               r_func;
    logic [WIDX_W-1:0]   r_wp, r_first_wp, r_last_wp;
    logic [OFF_W-1:0]    r_lo_off, r_hi_off;
    t_status             r_status;
    logic [IDX_W-1:0]    r_granted;
    logic [PG_W-1:0]     r_changed, r_used, r_reserved;
    logic [ADDR_W-1:0]   r_clr;
    logic [WORD_W-1:0]   r_rd_data;
    logic [WORD_W-1:0]   mem [DEPTH];

    logic [PG_W-1:0]     limit, lo, hi, hm1;
    logic [PG_W:0]       sum, sub;
    logic                skip0, empty, accept, last_word;
    t_wu_ctl             wu_ctl;
    t_wu_out             wu_res;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa, word_addr;

    function automatic logic [PG_W-1:0] sat_add(input logic [PG_W-1:0] c,
                                               input logic [CNT_W-1:0] n);
        logic [PG_W:0] s;
        s = {1'b0, c} + (PG_W+1)'(n);
        return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[PG_W-1:0];
    endfunction

    function automatic logic [PG_W-1:0] sat_sub(input logic [PG_W-1:0] c,
                                               input logic [CNT_W-1:0] n);
        return (c < PG_W'(n)) ? '0 : (c - PG_W'(n));
    endfunction

    // tracked limit and page range of the incoming request
    assign limit = (32'(i_total_pages) < MAX_PAGES) ? i_total_pages : PG_W'(MAX_PAGES);
    assign sum   = (PG_W+1)'(i_page_start) + (PG_W+1)'(i_run_length);

    always_comb begin
        if (i_func == FN_REQUEST) begin
            lo    = '0;
            hi    = limit;
            skip0 = 1'b0;
        end else begin
            lo    = PG_W'(i_page_start);
            hi    = (sum > (PG_W+1)'(limit)) ? limit : sum[PG_W-1:0];
            skip0 = (i_run_length != '0) && (sum > (PG_W+1)'(limit));
        end
    end

    assign hm1    = hi - PG_W'(1);
    assign empty  = (lo >= hi);
    assign accept = i_req_valid && o_req_ready;

    // shared word unit
    assign last_word     = (r_wp == r_last_wp);
    assign wu_ctl.func   = r_func;
    assign wu_ctl.first  = (r_wp == r_first_wp);
    assign wu_ctl.last   = last_word;
    assign wu_ctl.lo_off = r_lo_off;
    assign wu_ctl.hi_off = r_hi_off;

    pfba_word_unit u_word (
        .i_word (r_rd_data),
        .i_ctl  (wu_ctl),
        .o_res  (wu_res)
    );

    // bitmap memory, written by the clearing pass or the modify step
    assign word_addr = ADDR_W'(r_wp);
    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_MOD);
    assign mem_wa    = (r_state == S_CLEAR) ? r_clr : word_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= (r_state == S_CLEAR) ? '0 : wu_res.new_word;
        end
        if (r_state == S_RD) begin
            r_rd_data <= mem[word_addr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_used     <= '0;
            r_reserved <= '0;
            r_status   <= ST_OK;
            r_func     <= FN_LOCK;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_func     <= i_func;
                        r_granted  <= '0;
                        r_changed  <= '0;
                        r_wp       <= lo[PG_W-1:OFF_W];
                        r_first_wp <= lo[PG_W-1:OFF_W];
                        r_last_wp  <= hm1[PG_W-1:OFF_W];
                        r_lo_off   <= lo[OFF_W-1:0];
                        r_hi_off   <= hm1[OFF_W-1:0];
                        if (i_func == FN_REQUEST) begin
                            r_status <= ST_NONE;
                        end else begin
                            r_status <= skip0 ? ST_SKIP : ST_OK;
                        end
                        r_state <= empty ? S_DONE : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_changed <= r_changed + PG_W'(wu_res.chg_cnt);
                    unique case (r_func)
                        FN_FREE:    r_used     <= sat_sub(r_used, wu_res.chg_cnt);
                        FN_RESERVE: r_reserved <= sat_add(r_reserved, wu_res.chg_cnt);
                        default:    r_used     <= sat_add(r_used, wu_res.chg_cnt);
                    endcase
                    if (r_func != FN_REQUEST && wu_res.skip) begin
                        r_status <= ST_SKIP;
                    end
                    if (r_func == FN_REQUEST && wu_res.found) begin
                        r_status  <= ST_OK;
                        r_granted <= IDX_W'({r_wp, wu_res.found_off});
                        r_state   <= S_DONE;
                    end else if (last_word) begin
                        r_state <= S_DONE;
                    end else begin
                        r_wp    <= r_wp + WIDX_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result fields
    assign sub = {1'b0, r_used} + {1'b0, r_reserved};

    assign o_req_ready          = (r_state == S_IDLE);
    assign o_res_valid          = (r_state == S_DONE);
    assign o_res.status         = r_status;
    assign o_res.page_index     = r_granted;
    assign o_res.pages_changed  = r_changed;
    assign o_res.used_pages     = r_used;
    assign o_res.reserved_pages = r_reserved;
    assign o_res.free_pages     = ({1'b0, i_total_pages} > sub)
                                ? PG_W'({1'b0, i_total_pages} - sub) : '0;

    // checks
    `PFBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_req_ready)
    `PFBA_ASSERT(a_ready_not_done, i_clk, i_rst_n, !(o_req_ready && o_res_valid))
    `PFBA_ASSERT(a_wp_in_range, i_clk, i_rst_n,
        !(r_state == S_RD || r_state == S_MOD) || (r_wp <= r_last_wp))
    `PFBA_ASSERT_NEXT(a_grant_ends, i_clk, i_rst_n,
        (r_state == S_MOD) && (r_func == FN_REQUEST) && wu_res.found,
        o_res_valid && (o_res.status == ST_OK))

endmodule
`default_nettype wire

// ----- sim/tb_page_frame_bitmap_allocator_unit.sv -----
// self-checking testbench for the bitmap page frame allocator
module tb_page_frame_bitmap_allocator_unit
    import pfba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES          = DEF_MAX_PAGES;
    localparam int QUIET_LIMIT    = 50000;  // covers clearing pass plus full-map runs
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int ITEMS_PER_PHASE = 270;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [PG_W-1:0]  cfg_data = '0;
    logic             req_valid = 1'b0;
    logic [1:0]       req_func = '0;
    logic [IDX_W-1:0] req_page_start = '0;
    logic [PG_W-1:0]  req_run_length = '0;
    logic             res_ready = 1'b0;

    logic              o_cfg_ready;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [STAT_W-1:0] o_status;
    logic [IDX_W-1:0]  o_page_index;
    logic [PG_W-1:0]   o_pages_changed;
    logic [PG_W-1:0]   o_free_pages;
    logic [PG_W-1:0]   o_used_pages;
    logic [PG_W-1:0]   o_reserved_pages;

    // shadow copy of the allocator state
    bit      page_busy [PAGES];
    int      shadow_used = 0;
    int      shadow_reserved = 0;
    int      shadow_total = PAGES;
    t_result awaited_results [$];

    int mismatch_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_wait = 0;
    int quiet_cycles = 0;
    bit hold_req = 1'b0;

    page_frame_bitmap_allocator_unit #(
        .MAX_PAGES(PAGES)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (req_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (req_func),
        .i_page_start    (req_page_start),
        .i_run_length    (req_run_length),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (res_ready),
        .o_status        (o_status),
        .o_page_index    (o_page_index),
        .o_pages_changed (o_pages_changed),
        .o_free_pages    (o_free_pages),
        .o_used_pages    (o_used_pages),
        .o_reserved_pages(o_reserved_pages)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // apply one request to the shadow state and return the result it should give
    function automatic t_result apply_page_op(t_func f, int start, int len);
        t_result r;
        int limit, stop, idx, sub;
        r = '0;
        limit = (shadow_total < PAGES) ? shadow_total : PAGES;
        if (f == FN_REQUEST) begin
            r.status = ST_NONE;
            for (idx = 0; idx < limit; idx++) begin
                if (!page_busy[idx]) begin
                    page_busy[idx] = 1'b1;
                    if (shadow_used < int'(COUNT_MAX))
                        shadow_used++;
                    r.page_index = idx[IDX_W-1:0];
                    r.pages_changed = 1;
                    r.status = ST_OK;
                    break;
                end
            end
        end else begin
            stop = start + len;
            // pages at or past the limit are skipped
            if (len != 0 && stop > limit)
                r.status = ST_SKIP;
            if (stop > limit)
                stop = limit;
            for (idx = start; idx < stop; idx++) begin
                if (f == FN_FREE) begin
                    if (!page_busy[idx]) begin
                        r.status = ST_SKIP;
                        continue;
                    end
                    page_busy[idx] = 1'b0;
                    if (shadow_used > 0)
                        shadow_used--;
                end else begin
                    if (page_busy[idx]) begin
                        r.status = ST_SKIP;
                        continue;
                    end
                    page_busy[idx] = 1'b1;
                    if (f == FN_LOCK) begin
                        if (shadow_used < int'(COUNT_MAX))
                            shadow_used++;
                    end else if (shadow_reserved < int'(COUNT_MAX)) begin
                        shadow_reserved++;
                    end
                end
                r.pages_changed = r.pages_changed + 1'b1;
            end
        end
        sub = shadow_used + shadow_reserved;
        r.free_pages = (shadow_total > sub) ? PG_W'(shadow_total - sub) : '0;
        r.used_pages = PG_W'(shadow_used);
        r.reserved_pages = PG_W'(shadow_reserved);
        return r;
    endfunction

    // offer one request, hold it until taken, then record its expected result
    task automatic send_request(t_func f, int start, int len);
        int gap;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_func <= f;
        req_page_start <= start[IDX_W-1:0];
        req_run_length <= len[PG_W-1:0];
        do @(posedge clk); while (!o_in_ready);
        awaited_results.push_back(apply_page_op(f, start, len));
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_total_pages(int pages);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= pages[PG_W-1:0];
        do @(posedge clk); while (!o_cfg_ready);
        shadow_total = pages;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string name, logic [PG_W-1:0] want, logic [PG_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result side: random stalls, or one long hold when asked
    always @(posedge clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            rx_wait <= HOLD_CYCLES;
            res_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            res_ready <= 1'b0;
        end else begin
            rx_wait <= pick_gap(rx_idle_pct);
            res_ready <= 1'b1;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge clk) begin : result_check
        t_result want;
        if (o_out_valid && res_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d page %0d changed %0d",
                         $time, o_status, o_page_index, o_pages_changed);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", PG_W'(want.status), PG_W'(o_status));
                check_field("page_index", PG_W'(want.page_index), PG_W'(o_page_index));
                check_field("pages_changed", want.pages_changed, o_pages_changed);
                check_field("free_pages", want.free_pages, o_free_pages);
                check_field("used_pages", want.used_pages, o_used_pages);
                check_field("reserved_pages", want.reserved_pages, o_reserved_pages);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk) begin
        if ((req_valid && o_in_ready) || (o_out_valid && res_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // lock, free, reserve and request basics at the reset limit
    task automatic test_basic_runs();
        send_request(FN_REQUEST, 0, 0);         // lowest page of an empty map
        send_request(FN_LOCK, 0, 0);            // empty run
        send_request(FN_LOCK, 0, 40);           // first page already busy
        send_request(FN_FREE, 10, 5);
        send_request(FN_REQUEST, 0, 0);         // hole left by the free
        send_request(FN_RESERVE, 60, 8);
        send_request(FN_RESERVE, 62, 2);        // reserve over reserved pages
        send_request(FN_FREE, 60, 4);           // free of reserved pages hits used count
        send_request(FN_FREE, 200, 3);          // free of clear pages
        send_request(FN_LOCK, 65535, 1);        // top page
        send_request(FN_LOCK, 65530, 65536);    // run past the limit
        send_request(FN_FREE, 0, 65536);        // used count bottoms out at zero
        send_request(FN_REQUEST, 1234, 77);     // run fields ignored
    endtask

    // lowered and raised limits, including zero
    task automatic test_page_limit();
        write_total_pages(0);
        send_request(FN_REQUEST, 0, 0);
        send_request(FN_LOCK, 0, 1);
        write_total_pages(33);
        send_request(FN_LOCK, 0, 33);
        send_request(FN_REQUEST, 0, 0);
        send_request(FN_FREE, 32, 1);
        write_total_pages(32);
        send_request(FN_REQUEST, 0, 0);
        send_request(FN_LOCK, 32, 1);           // out of reach, bit kept
        write_total_pages(65536);
        send_request(FN_REQUEST, 0, 0);
    endtask

    // whole map busy: request finds nothing
    task automatic test_full_map();
        send_request(FN_LOCK, 0, 65536);
        send_request(FN_REQUEST, 0, 0);
        send_request(FN_FREE, 0, 65536);
    endtask

    // random requests over several limits, with and without idling
    task automatic test_random_traffic();
        int phase_totals[6] = '{65536, 1000, 37, 65535, 0, 65536};
        int phase, pick, start, len;
        t_func f;
        phase_totals[4] = $urandom_range(1, 65536);
        for (phase = 0; phase < 6; phase++) begin
            write_total_pages(phase_totals[phase]);
            tx_idle_pct = (phase == 0) ? 0 : 30;
            rx_idle_pct = (phase == 0 || phase == 3) ? 0 : 30;
            repeat (ITEMS_PER_PHASE) begin
                f = t_func'($urandom_range(0, 3));
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // busy low window keeps the search short
                    start = $urandom_range(0, 511);
                    len = $urandom_range(0, 40);
                end else if (pick < 85) begin
                    start = $urandom_range(0, 65535);
                    len = $urandom_range(0, 8);
                end else if (pick < 97) begin
                    // long runs that mostly fall past the limit
                    start = 65535 - $urandom_range(0, 300);
                    len = $urandom_range(0, 65536);
                end else begin
                    start = $urandom_range(0, 65535);
                    len = $urandom_range(0, 65536);
                    if (f == FN_RESERVE)
                        f = FN_LOCK;
                end
                send_request(f, start, len);
            end
        end
    endtask

    // results held off while requests keep coming
    task automatic test_backpressure();
        wait_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        repeat (20)
            send_request(t_func'($urandom_range(0, 3)), $urandom_range(0, 127),
                         $urandom_range(0, 16));
        rx_idle_pct = 30;
    endtask

    // reserved count driven to its ceiling, free pages to zero
    task automatic test_count_saturation();
        write_total_pages(65536);
        send_request(FN_RESERVE, 0, 65536);
        send_request(FN_FREE, 0, 65536);
        send_request(FN_RESERVE, 0, 65536);
        send_request(FN_RESERVE, 0, 65536);
        send_request(FN_FREE, 0, 65536);
        send_request(FN_RESERVE, 0, 10);
        send_request(FN_REQUEST, 0, 0);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_runs();
        test_page_limit();
        test_full_map();
        test_random_traffic();
        test_backpressure();
        test_count_saturation();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
